/* rtl/b64d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and tables of the strict base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CHAR_W     = 8;
  localparam int POS_W      = 24;
  localparam int ACC_W      = 24;
  localparam int APB_AW     = 2;
  localparam int APB_DW     = 32;

  localparam longint unsigned MAX_MESSAGE_CHARS = 64'd16777216;
  localparam logic [POS_W-1:0] POS_LIMIT =
    ((MAX_MESSAGE_CHARS - 64'd1) > 64'hFFFFFF) ? 24'hFFFFFF
                                               : POS_W'(MAX_MESSAGE_CHARS - 64'd1);

  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [APB_AW-1:0] REG_SKIP_MODE = 2'd0;

  localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

  localparam logic [ACC_W-1:0] MASK_TWO_PAD = 24'h00FFFF;
  localparam logic [ACC_W-1:0] MASK_OTHER   = 24'h0000FF;

  typedef enum logic [1:0] {
    SKIP_NONE = 2'd0,
    SKIP_WS   = 2'd1,
    SKIP_EOL  = 2'd2
  } skip_mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_PAD_BITS   = 3'd1,
    ST_AFTER_PAD  = 3'd2,
    ST_INVALID    = 3'd3,
    ST_LEN_ONE    = 3'd4,
    ST_PART_PAD   = 3'd5,
    ST_MISSING    = 3'd6
  } status_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             byte_valid;
    logic             message_done;
    status_t          status;
    logic [POS_W-1:0] error_position;
    logic             run_last;
  } result_t;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    sextet_of = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      sextet_of = {1'b0, d[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61 + 8'd26;
      sextet_of = {1'b0, d[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      d = c - 8'h30 + 8'd52;
      sextet_of = {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      sextet_of = 7'd62;
    end else if (c == 8'h2F) begin
      sextet_of = 7'd63;
    end
  endfunction

  function automatic result_t byte_result(input logic [7:0] b);
    result_t r;
    r = '0;
    r.data_byte  = b;
    r.byte_valid = 1'b1;
    r.status     = ST_OK;
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/b64d_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_text_if / b64d_result_if
// Valid/ready channels for encoded text in and decoded results out.
// ----------------------------------------------------------------------------
interface b64d_text_if;
  import b64d_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_in;
  logic              message_end;

  modport source (output valid, char_in, message_end, input ready);
  modport sink   (input valid, char_in, message_end, output ready);
endinterface

interface b64d_result_if;
  import b64d_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic             byte_valid;
  logic             message_done;
  status_t          status;
  logic [POS_W-1:0] error_position;
  logic             run_last;

  modport source (output valid, data_byte, byte_valid, message_done, status,
                  error_position, run_last, input ready);
  modport sink   (input valid, data_byte, byte_valid, message_done, status,
                  error_position, run_last, output ready);
endinterface
`default_nettype wire

/* rtl/base64_strict_decoder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_strict_decoder
// Streaming strict base64 decoder with APB mode register.
// ----------------------------------------------------------------------------
// One character is taken per cycle into an input register, decoded from
// there once the queue has room, and its results (up to three) written into
// an eight-entry result queue, from which one result leaves per cycle while
// result.ready is high. The input stalls only while the queue has fewer than
// three free entries, so a stream of four-character groups runs at one
// character per cycle and the output side sets the rate when it drains more
// slowly than three results per four characters. The skip_mode register
// (byte address 0) is to be written over APB only while the decoder is idle;
// the block itself does not enforce this; pready is always high.
module base64_strict_decoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [b64d_pkg::APB_AW-1:0]  paddr,
  input  wire logic [b64d_pkg::APB_DW-1:0]  pwdata,
  output      logic [b64d_pkg::APB_DW-1:0]  prdata,
  output      logic                         pready,
  b64d_text_if.sink                         text,
  b64d_result_if.source                     result
);
  import b64d_pkg::*;

  logic [1:0]          skip_mode;
  logic                stage_valid;
  logic [CHAR_W-1:0]   stage_char;
  logic                stage_end;
  logic                fire;
  logic                take;
  logic [1:0]          res_count;
  result_t             res [MAX_RESULTS];
  logic [QUEUE_CW-1:0] q_count;
  result_t             q_head;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_SKIP_MODE) ? {{(APB_DW-2){1'b0}}, skip_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_mode <= SKIP_NONE;
    end else if (psel && penable && pwrite && pready && paddr == REG_SKIP_MODE) begin
      skip_mode <= pwdata[1:0];
    end
  end

  assign fire       = stage_valid && (q_count <= QUEUE_CW'(QUEUE_DEPTH - MAX_RESULTS));
  assign text.ready = !stage_valid || fire;
  assign take       = text.valid && text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (take) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_char <= text.char_in;
      stage_end  <= text.message_end;
    end
  end

  b64d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .char_in   (stage_char),
    .msg_end   (stage_end),
    .skip_mode (skip_mode),
    .res_count (res_count),
    .res       (res)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (res_count),
    .push_data  (res),
    .pop        (result.valid && result.ready),
    .count      (q_count),
    .head       (q_head)
  );

  assign result.valid          = (q_count != '0);
  assign result.data_byte      = q_head.data_byte;
  assign result.byte_valid     = q_head.byte_valid;
  assign result.message_done   = q_head.message_done;
  assign result.status         = q_head.status;
  assign result.error_position = q_head.error_position;
  assign result.run_last       = q_head.run_last;

endmodule
`default_nettype wire

/* rtl/b64d_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_decode
// Per-character decode: message state and up to three results per character.
// ----------------------------------------------------------------------------
module b64d_decode (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      fire,
  input  wire logic [b64d_pkg::CHAR_W-1:0] char_in,
  input  wire logic                      msg_end,
  input  wire logic [1:0]                skip_mode,
  output      logic [1:0]                res_count,
  output      b64d_pkg::result_t         res [b64d_pkg::MAX_RESULTS]
);
  import b64d_pkg::*;

  logic [ACC_W-1:0] acc, acc_next;
  logic [1:0]       cnt, cnt_next;
  logic             pad_seen, pad_seen_next;
  logic [2:0]       pad_sextets, pad_sextets_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             dropping, dropping_next;

  logic [6:0]       sext;
  logic [ACC_W-1:0] acc_sh;
  logic [ACC_W-1:0] acc_dat;
  logic [ACC_W-1:0] mask;
  logic [2:0]       pad_inc;
  logic             grp_done;
  logic             skip;
  status_t          err;

  assign sext     = sextet_of(char_in);
  assign acc_sh   = {acc[ACC_W-7:0], 6'd0};
  assign acc_dat  = {acc[ACC_W-7:0], sext[5:0]};
  assign grp_done = (cnt == 2'd3);
  assign pad_inc  = pad_sextets + 3'd1;
  assign mask     = (pad_inc == 3'd2) ? MASK_TWO_PAD : MASK_OTHER;

  always_comb begin
    case (skip_mode)
      SKIP_WS:   skip = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
                        (char_in == CH_CR) || (char_in == CH_LF);
      SKIP_EOL:  skip = (char_in == CH_CR) || (char_in == CH_LF);
      default:   skip = 1'b0;
    endcase
  end

  always_comb begin
    acc_next         = acc;
    cnt_next         = cnt;
    pad_seen_next    = pad_seen;
    pad_sextets_next = pad_sextets;
    pos_next         = pos;
    dropping_next    = dropping;
    res_count        = 2'd0;
    err              = ST_OK;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k] = '0;
    end

    if (fire) begin
      if (dropping) begin
        if (msg_end) begin
          acc_next         = '0;
          cnt_next         = '0;
          pad_seen_next    = 1'b0;
          pad_sextets_next = '0;
          pos_next         = '0;
          dropping_next    = 1'b0;
        end
      end else begin
        if (char_in == CH_PAD) begin
          pad_seen_next = 1'b1;
          if (grp_done) begin
            if ((acc_sh & mask) != '0) begin
              err = ST_PAD_BITS;
            end else begin
              res[0] = byte_result(acc_sh[23:16]);
              res_count = 2'd1;
              if (pad_inc == 3'd1) begin
                res[1] = byte_result(acc_sh[15:8]);
                res_count = 2'd2;
              end
            end
            acc_next         = '0;
            cnt_next         = '0;
            pad_sextets_next = '0;
          end else begin
            acc_next         = acc_sh;
            cnt_next         = cnt + 2'd1;
            pad_sextets_next = pad_inc;
          end
        end else if (!skip) begin
          if (pad_seen) begin
            err = ST_AFTER_PAD;
          end else if (sext[6]) begin
            err = ST_INVALID;
          end else if (grp_done) begin
            res[0] = byte_result(acc_dat[23:16]);
            res[1] = byte_result(acc_dat[15:8]);
            res[2] = byte_result(acc_dat[7:0]);
            res_count = 2'd3;
            acc_next  = '0;
            cnt_next  = '0;
          end else begin
            acc_next = acc_dat;
            cnt_next = cnt + 2'd1;
          end
        end

        if (err == ST_OK && msg_end) begin
          if (cnt_next == 2'd1) begin
            err = ST_LEN_ONE;
          end else if (cnt_next != 2'd0) begin
            err = pad_seen_next ? ST_PART_PAD : ST_MISSING;
          end
        end

        if (err != ST_OK) begin
          for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
          end
          res[0].message_done   = 1'b1;
          res[0].status         = err;
          res[0].error_position = pos;
          res_count = 2'd1;
          if (!msg_end) begin
            dropping_next = 1'b1;
          end
        end else if (msg_end) begin
          if (res_count == 2'd0) begin
            res[0].message_done = 1'b1;
            res[0].status       = ST_OK;
            res_count = 2'd1;
          end else begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
              if (res_count == 2'(k + 1)) begin
                res[k].message_done = 1'b1;
              end
            end
          end
        end else if (pos < POS_LIMIT) begin
          pos_next = pos + POS_W'(1);
        end

        if (msg_end) begin
          acc_next         = '0;
          cnt_next         = '0;
          pad_seen_next    = 1'b0;
          pad_sextets_next = '0;
          pos_next         = '0;
          dropping_next    = 1'b0;
        end

        for (int k = 0; k < MAX_RESULTS; k++) begin
          if (res_count == 2'(k + 1)) begin
            res[k].run_last = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      cnt         <= '0;
      pad_seen    <= 1'b0;
      pad_sextets <= '0;
      pos         <= '0;
      dropping    <= 1'b0;
    end else begin
      acc         <= acc_next;
      cnt         <= cnt_next;
      pad_seen    <= pad_seen_next;
      pad_sextets <= pad_sextets_next;
      pos         <= pos_next;
      dropping    <= dropping_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/b64d_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64d_queue
// Result queue: up to three words written per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [1:0]                    push_count,
  input  wire b64d_pkg::result_t             push_data [b64d_pkg::MAX_RESULTS],
  input  wire logic                          pop,
  output      logic [b64d_pkg::QUEUE_CW-1:0] count,
  output      b64d_pkg::result_t             head
);
  import b64d_pkg::*;

  result_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr, rptr;
  logic [QUEUE_CW-1:0] count_next;

  assign head       = mem[rptr];
  assign count_next = count + QUEUE_CW'(push_count) - QUEUE_CW'(pop);

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < push_count) begin
        mem[wptr + QUEUE_AW'(k)] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + QUEUE_AW'(push_count);
      rptr  <= rptr + QUEUE_AW'(pop);
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

/* bench/tb_base64_strict_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_strict_decoder
// Self-checking bench for the strict base64 decoder. A short table of directed
// characters covers alphabet extremes, padding rules, every error kind but
// ST_MISSING and every skip mode. Random messages follow, mostly well-formed
// with some noise, over several skip_mode settings written over APB. Every
// word is checked against an in-bench model, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_base64_strict_decoder;
  import b64d_pkg::*;

  localparam logic [1:0] SKIP_SPARE = 2'd3;
  localparam int IDLE_PCT   = 25;
  localparam int SETTLE     = 12;
  localparam int REPORT_CAP = 60;

  typedef struct {
    logic [7:0]       ch;
    logic             last;
    logic [1:0]       mode;
    logic             typed;
    status_t          st;
    logic [POS_W-1:0] at;
  } stim_row_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  b64d_text_if   text_ch();
  b64d_result_if result_ch();

  base64_strict_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .text    (text_ch),
    .result  (result_ch)
  );

  string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  string blanks   = " \t\r\n";

  // decoder model state
  logic [ACC_W-1:0] acc;
  logic [1:0]       sextets;
  logic             pad_seen;
  logic [2:0]       pad_run;
  logic [POS_W-1:0] char_pos;
  logic             dropping;
  logic [1:0]       mode;

  result_t expected_words[$];
  int      mismatches;
  int      chars_sent;
  logic    calm;

  stim_row_t directed_rows [28] = '{
    '{"Z",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"m",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"9",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"v",   1'b1, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"/",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"w",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b1, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"A",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b1, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"Q",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"Q",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b1, SKIP_NONE,  1'b1, ST_PART_PAD,  24'd2},
    '{"A",   1'b1, SKIP_NONE,  1'b1, ST_LEN_ONE,   24'd0},
    '{"Q",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"R",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"=",   1'b1, SKIP_NONE,  1'b1, ST_PAD_BITS,  24'd3},
    '{"=",   1'b0, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{"A",   1'b0, SKIP_NONE,  1'b1, ST_AFTER_PAD, 24'd1},
    '{8'hFF, 1'b1, SKIP_NONE,  1'b0, ST_OK,        24'd0},
    '{8'h00, 1'b1, SKIP_NONE,  1'b1, ST_INVALID,   24'd0},
    '{" ",   1'b1, SKIP_WS,    1'b1, ST_OK,        24'd0},
    '{" ",   1'b1, SKIP_EOL,   1'b1, ST_INVALID,   24'd0},
    '{"\n",  1'b1, SKIP_EOL,   1'b1, ST_OK,        24'd0},
    '{"\n",  1'b1, SKIP_SPARE, 1'b1, ST_INVALID,   24'd0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("%0t ns: %s", $time, what);
  endtask

  function automatic int sextet_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (alphabet[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic result_t byte_word(input logic [7:0] b);
    result_t w;
    w = '0;
    w.data_byte  = b;
    w.byte_valid = 1'b1;
    w.status     = ST_OK;
    return w;
  endfunction

  function automatic result_t end_word(input status_t st, input logic [POS_W-1:0] at);
    result_t w;
    w = '0;
    w.message_done   = 1'b1;
    w.status         = st;
    w.error_position = at;
    w.run_last       = 1'b1;
    return w;
  endfunction

  function automatic void clear_message();
    acc      = '0;
    sextets  = '0;
    pad_seen = 1'b0;
    pad_run  = '0;
    char_pos = '0;
    dropping = 1'b0;
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic last,
                                      output result_t burst[$]);
    status_t          fault;
    logic [POS_W-1:0] here;
    logic [ACC_W-1:0] mask;
    int               cnt;
    int               v;
    logic             skip;
    burst = {};
    fault = ST_OK;
    here  = char_pos;
    cnt   = sextets;
    if (dropping) begin
      if (last) clear_message();
      return;
    end
    skip = (mode == SKIP_WS && (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) ||
           (mode == SKIP_EOL && (c == CH_CR || c == CH_LF));
    if (c == CH_PAD) begin
      pad_seen = 1'b1;
      acc      = acc << 6;
      cnt++;
      pad_run  = pad_run + 3'd1;
      if (cnt == 4) begin
        mask = (pad_run == 3'd2) ? 24'h00FFFF : 24'h0000FF;
        if ((acc & mask) != '0) begin
          fault = ST_PAD_BITS;
        end else begin
          burst.push_back(byte_word(acc[23:16]));
          if (pad_run == 3'd1) burst.push_back(byte_word(acc[15:8]));
        end
        acc     = '0;
        cnt     = 0;
        pad_run = '0;
      end
    end else if (!skip) begin
      v = sextet_value(c);
      if (pad_seen) begin
        fault = ST_AFTER_PAD;
      end else if (v < 0) begin
        fault = ST_INVALID;
      end else begin
        acc = (acc << 6) | ACC_W'(v);
        cnt++;
        if (cnt == 4) begin
          burst.push_back(byte_word(acc[23:16]));
          burst.push_back(byte_word(acc[15:8]));
          burst.push_back(byte_word(acc[7:0]));
          acc = '0;
          cnt = 0;
        end
      end
    end
    sextets = 2'(cnt);

    if (fault == ST_OK && last) begin
      if (cnt == 1) fault = ST_LEN_ONE;
      else if (cnt != 0) fault = pad_seen ? ST_PART_PAD : ST_MISSING;
    end

    if (fault != ST_OK) begin
      burst = {end_word(fault, here)};
      if (last) clear_message();
      else dropping = 1'b1;
    end else if (last) begin
      if (burst.size() == 0) burst.push_back(end_word(ST_OK, '0));
      else burst[burst.size()-1].message_done = 1'b1;
      clear_message();
    end else if (char_pos < POS_LIMIT) begin
      char_pos++;
    end
    if (burst.size() != 0) burst[burst.size()-1].run_last = 1'b1;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.char_in     <= c;
    text_ch.message_end <= last;
    @(posedge clk);
    while (!text_ch.ready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic predict_and_send(input logic [7:0] c, input logic last);
    result_t burst[$];
    decode_char(c, last, burst);
    foreach (burst[i]) expected_words.push_back(burst[i]);
    send_char(c, last);
  endtask

  task automatic go_idle();
    text_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SKIP_MODE;
    pwdata  <= APB_DW'(m);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mode = m;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] some_blank();
    return blanks[$urandom_range(3)];
  endfunction

  task automatic send_message();
    logic [7:0] msg[$];
    logic [5:0] s;
    int         groups;
    int         len;
    if ($urandom_range(99) < 80) begin
      groups = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
      repeat (groups) repeat (4) msg.push_back(alphabet[$urandom_range(63)]);
      case ($urandom_range(5))
        1: begin
          msg.push_back(alphabet[$urandom_range(63)]);
          s = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(3) << 4);
          msg.push_back(alphabet[s]);
          msg.push_back(CH_PAD);
          msg.push_back(CH_PAD);
        end
        2: begin
          msg.push_back(alphabet[$urandom_range(63)]);
          msg.push_back(alphabet[$urandom_range(63)]);
          s = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(15) << 2);
          msg.push_back(alphabet[s]);
          msg.push_back(CH_PAD);
        end
        3: begin
          if ($urandom_range(1)) msg.push_back(alphabet[$urandom_range(3) << 2]);
          else msg.push_back(CH_PAD);
          repeat (3) msg.push_back(CH_PAD);
        end
        default: ;
      endcase
      if (msg.size() == 0 || $urandom_range(3) == 0) begin
        repeat (1 + $urandom_range(2)) msg.insert($urandom_range(msg.size()), some_blank());
      end
    end else begin
      len = 1 + $urandom_range(9);
      repeat (len) begin
        case ($urandom_range(3))
          0: msg.push_back(alphabet[$urandom_range(63)]);
          1: msg.push_back(CH_PAD);
          2: msg.push_back(some_blank());
          default: msg.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    foreach (msg[i]) predict_and_send(msg[i], i == msg.size() - 1);
  endtask

  // output side: random stalls, checked at the rising edge
  always @(negedge clk) begin
    result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word, data %02h status %0d",
                         result_ch.data_byte, result_ch.status));
      end else begin
        want = expected_words.pop_front();
        if (result_ch.data_byte !== want.data_byte)
          report($sformatf("data_byte %02h, want %02h", result_ch.data_byte, want.data_byte));
        if (result_ch.byte_valid !== want.byte_valid)
          report($sformatf("byte_valid %b, want %b", result_ch.byte_valid, want.byte_valid));
        if (result_ch.message_done !== want.message_done)
          report($sformatf("message_done %b, want %b",
                           result_ch.message_done, want.message_done));
        if (result_ch.status !== want.status)
          report($sformatf("status %0d, want %0d", result_ch.status, want.status));
        if (result_ch.error_position !== want.error_position)
          report($sformatf("error_position %0d, want %0d",
                           result_ch.error_position, want.error_position));
        if (result_ch.run_last !== want.run_last)
          report($sformatf("run_last %b, want %b", result_ch.run_last, want.run_last));
      end
    end
  end

  initial begin
    logic [1:0] phase_modes [6];
    result_t    burst[$];
    int         goal;
    phase_modes = '{SKIP_WS, SKIP_NONE, SKIP_EOL, SKIP_SPARE, SKIP_WS, SKIP_NONE};
    mismatches          = 0;
    chars_sent          = 0;
    calm                = 1'b0;
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    text_ch.valid       = 1'b0;
    text_ch.char_in     = '0;
    text_ch.message_end = 1'b0;
    result_ch.ready     = 1'b0;
    mode                = SKIP_NONE;
    clear_message();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != mode) begin
        go_idle();
        write_mode(directed_rows[i].mode);
      end
      decode_char(directed_rows[i].ch, directed_rows[i].last, burst);
      if (directed_rows[i].typed)
        expected_words.push_back(end_word(directed_rows[i].st, directed_rows[i].at));
      else
        foreach (burst[k]) expected_words.push_back(burst[k]);
      send_char(directed_rows[i].ch, directed_rows[i].last);
    end

    foreach (phase_modes[p]) begin
      go_idle();
      write_mode(phase_modes[p]);
      calm = (p == 2);
      goal = chars_sent + 85;
      while (chars_sent < goal) send_message();
    end
    calm = 1'b0;

    go_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* base64_strict_decoder.f */
rtl/b64d_pkg.sv
rtl/b64d_if.sv
rtl/b64d_decode.sv
rtl/b64d_queue.sv
rtl/base64_strict_decoder.sv
bench/tb_base64_strict_decoder.sv
